@@ sv/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared codes for the cluster chain table engine: operation modes, status
// codes, sequencer states and fixed link constants.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_ALLOC = 3'd2;
    localparam logic [2:0] MODE_LINK  = 3'd3;
    localparam logic [2:0] MODE_FREE  = 3'd4;
    localparam logic [2:0] MODE_WALK  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_RUNAWAY = 2'd3;

    localparam int unsigned FIRST_DATA   = 2;
    localparam logic [15:0] MARKER_MIN   = 16'hFFF8;
    localparam logic [15:0] MARKER_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_LINK,
        S_CHAIN,
        S_FOLLOW
    } cct_state_t;

endpackage

@@ sv/cct_link_ram.sv @@
// ----------------------------------------------------------------------------
// cct_link_ram
// Link table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cct_link_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [15:0]              wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [15:0]              rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/cct_seq.sv @@
// ----------------------------------------------------------------------------
// cct_seq
// Operation sequencer: clearing pass, link read/write, free-entry scan,
// chain free and chain walk; scan and chain free read before they write.
// ----------------------------------------------------------------------------
module cct_seq #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [2:0]                       mode,
    input  logic [15:0]                      cluster,
    input  logic [15:0]                      link_value,
    input  logic [12:0]                      step_limit,
    input  logic [15:0]                      end_marker,
    output logic                             busy,
    output logic                             done,
    output logic [15:0]                      result_value,
    output logic [12:0]                      entries_touched,
    output logic [1:0]                       status,
    output logic                             mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] mem_waddr,
    output logic [15:0]                      mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0] mem_raddr,
    input  logic [15:0]                      mem_rdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [16:0]      TE_EXT    = 17'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] TE_CNT    = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FIRST_CNT = CNT_W'(cct_pkg::FIRST_DATA);

    cct_pkg::cct_state_t state_reg, state_next;

    logic             done_reg, done_next;
    logic [2:0]       mode_reg, mode_next;
    logic [15:0]      key_reg, key_next;
    logic [12:0]      limit_reg, limit_next;
    logic [15:0]      cur_reg, cur_next;
    logic [CNT_W-1:0] touched_reg, touched_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0] got_reg, got_next;
    logic             fwd_vld_reg, fwd_vld_next;
    logic [15:0]      fwd_data_reg, fwd_data_next;
    logic [15:0]      result_reg, result_next;
    logic [12:0]      touched_out_reg, touched_out_next;
    logic [1:0]       status_reg, status_next;

    logic             accept;
    logic             in_table;
    logic [15:0]      link;
    logic             is_walk;
    logic             is_free;
    logic [15:0]      cur_c;
    logic [CNT_W-1:0] tch_c;
    logic             chain_end;
    logic             chain_oob;
    logic             chain_run;
    logic             chain_go;
    logic             scan_hit;
    logic             scan_more;
    logic             scan_full;

    assign busy     = (state_reg != cct_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign in_table = {1'b0, cluster} < TE_EXT;
    assign link     = fwd_vld_reg ? fwd_data_reg : mem_rdata;
    assign is_walk  = (mode_reg == cct_pkg::MODE_WALK);
    assign is_free  = (mode_reg == cct_pkg::MODE_FREE);

    assign cur_c = (state_reg == cct_pkg::S_FOLLOW) ? link : cur_reg;
    assign tch_c = (state_reg == cct_pkg::S_FOLLOW) ? CNT_W'(touched_reg + 1'b1)
                                                    : touched_reg;
    assign chain_end = (cur_c >= end_marker)
                    || (is_walk && !(17'(tch_c) < 17'(limit_reg)));
    assign chain_oob = 17'(cur_c) >= TE_EXT;
    assign chain_run = tch_c >= TE_CNT;
    assign chain_go  = !chain_end && !chain_oob && !chain_run;

    assign scan_hit  = rd_vld_reg && (link == 16'd0) && (16'(rd_addr_reg) != key_reg);
    assign scan_more = ptr_reg < TE_CNT;
    assign scan_full = !rd_vld_reg && !scan_more;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cct_pkg::S_CLEAR:
            begin
                if (ptr_reg == LAST_CNT)
                begin
                    state_next = cct_pkg::S_IDLE;
                end
            end
            cct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        cct_pkg::MODE_READ:
                            state_next = in_table ? cct_pkg::S_READ : cct_pkg::S_IDLE;
                        cct_pkg::MODE_ALLOC:
                            state_next = cct_pkg::S_SCAN;
                        cct_pkg::MODE_LINK:
                            state_next = in_table ? cct_pkg::S_SCAN : cct_pkg::S_IDLE;
                        cct_pkg::MODE_FREE, cct_pkg::MODE_WALK:
                            state_next = cct_pkg::S_CHAIN;
                        default:
                            state_next = cct_pkg::S_IDLE;
                    endcase
                end
            end
            cct_pkg::S_READ:
                state_next = cct_pkg::S_IDLE;
            cct_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = (mode_reg == cct_pkg::MODE_LINK) ? cct_pkg::S_LINK
                                                                  : cct_pkg::S_IDLE;
                end
                else if (scan_full)
                begin
                    state_next = cct_pkg::S_IDLE;
                end
            end
            cct_pkg::S_LINK:
                state_next = cct_pkg::S_IDLE;
            cct_pkg::S_CHAIN, cct_pkg::S_FOLLOW:
                state_next = chain_go ? cct_pkg::S_FOLLOW : cct_pkg::S_IDLE;
            default:
                state_next = cct_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        done_next        = 1'b0;
        mode_next        = mode_reg;
        key_next         = key_reg;
        limit_next       = limit_reg;
        cur_next         = cur_reg;
        touched_next     = touched_reg;
        ptr_next         = ptr_reg;
        rd_vld_next      = 1'b0;
        rd_addr_next     = rd_addr_reg;
        got_next         = got_reg;
        result_next      = result_reg;
        touched_out_next = touched_out_reg;
        status_next      = status_reg;

        case (state_reg)
            cct_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                ptr_next  = CNT_W'(ptr_reg + 1'b1);
            end
            cct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mode_next        = mode;
                    limit_next       = step_limit;
                    cur_next         = cluster;
                    touched_next     = '0;
                    ptr_next         = FIRST_CNT;
                    key_next         = (mode == cct_pkg::MODE_LINK) ? cluster : 16'd0;
                    result_next      = 16'd0;
                    touched_out_next = 13'd0;
                    status_next      = cct_pkg::ST_OK;
                    case (mode)
                        cct_pkg::MODE_READ:
                        begin
                            if (in_table)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = cluster[IDX_W-1:0];
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = cct_pkg::ST_RANGE;
                            end
                        end
                        cct_pkg::MODE_WRITE:
                        begin
                            done_next = 1'b1;
                            if (in_table)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cluster[IDX_W-1:0];
                                mem_wdata = link_value;
                            end
                            else
                            begin
                                status_next = cct_pkg::ST_RANGE;
                            end
                        end
                        cct_pkg::MODE_ALLOC:
                        begin
                        end
                        cct_pkg::MODE_LINK:
                        begin
                            if (!in_table)
                            begin
                                done_next   = 1'b1;
                                status_next = cct_pkg::ST_RANGE;
                            end
                        end
                        cct_pkg::MODE_FREE, cct_pkg::MODE_WALK:
                        begin
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            cct_pkg::S_READ:
            begin
                done_next   = 1'b1;
                result_next = link;
            end
            cct_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg;
                    mem_wdata = end_marker;
                    got_next  = rd_addr_reg;
                    if (mode_reg != cct_pkg::MODE_LINK)
                    begin
                        done_next   = 1'b1;
                        result_next = 16'(rd_addr_reg);
                    end
                end
                else if (scan_full)
                begin
                    done_next   = 1'b1;
                    status_next = cct_pkg::ST_FULL;
                end
                else if (scan_more)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = ptr_reg[IDX_W-1:0];
                    rd_vld_next  = 1'b1;
                    rd_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = CNT_W'(ptr_reg + 1'b1);
                end
            end
            cct_pkg::S_LINK:
            begin
                mem_we      = 1'b1;
                mem_waddr   = key_reg[IDX_W-1:0];
                mem_wdata   = 16'(got_reg);
                done_next   = 1'b1;
                result_next = 16'(got_reg);
            end
            cct_pkg::S_CHAIN, cct_pkg::S_FOLLOW:
            begin
                if ((state_reg == cct_pkg::S_FOLLOW) && is_free)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg[IDX_W-1:0];
                end
                cur_next     = cur_c;
                touched_next = tch_c;
                if (chain_go)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_c[IDX_W-1:0];
                end
                else
                begin
                    done_next        = 1'b1;
                    result_next      = is_walk ? cur_c : 16'd0;
                    touched_out_next = 13'(tch_c);
                    if (chain_end)
                    begin
                        status_next = cct_pkg::ST_OK;
                    end
                    else if (chain_oob)
                    begin
                        status_next = cct_pkg::ST_RANGE;
                    end
                    else
                    begin
                        status_next = cct_pkg::ST_RUNAWAY;
                    end
                end
            end
            default:
            begin
            end
        endcase

        fwd_vld_next  = mem_re && mem_we && (mem_raddr == mem_waddr);
        fwd_data_next = mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cct_pkg::S_CLEAR;
            done_reg    <= 1'b0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            mode_reg    <= cct_pkg::MODE_READ;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            fwd_vld_reg <= fwd_vld_next;
            mode_reg    <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        limit_reg       <= limit_next;
        cur_reg         <= cur_next;
        touched_reg     <= touched_next;
        rd_addr_reg     <= rd_addr_next;
        got_reg         <= got_next;
        fwd_data_reg    <= fwd_data_next;
        result_reg      <= result_next;
        touched_out_reg <= touched_out_next;
        status_reg      <= status_next;
    end

    assign done            = done_reg;
    assign result_value    = result_reg;
    assign entries_touched = touched_out_reg;
    assign status          = status_reg;

endmodule

@@ sv/cluster_chain_table_engine.sv @@
// ----------------------------------------------------------------------------
// cluster_chain_table_engine
// File allocation table of 16-bit link words with read, write, allocate,
// allocate-and-link, free-chain and walk operations.
//
// A command transfers at a rising edge with start high and busy low; mode,
// cluster, link_value and step_limit are sampled there. Each command gives
// one result: done is high for exactly one cycle with result_value,
// entries_touched and status; the receiver cannot stall it.
// Write and rejected commands finish straight from idle; read waits for its
// table read; allocate scans for a free entry and allocate-and-link then
// writes the link. The scan and chain loops issue one table read per cycle
// through the single read port; one command is in work at a time.
// After reset a clearing pass writes every entry to zero with busy high.
// cfg_we/cfg_data load end_marker at any time; values below 0xFFF8 are raised
// to 0xFFF8; reset value 0xFFFF.
// ----------------------------------------------------------------------------
module cluster_chain_table_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [15:0] cluster,
    input  logic [15:0] link_value,
    input  logic [12:0] step_limit,
    output logic        done,
    output logic [15:0] result_value,
    output logic [12:0] entries_touched,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [15:0] end_marker_reg, end_marker_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [15:0]      mem_rdata;

    always_comb
    begin
        end_marker_next = end_marker_reg;
        if (cfg_we)
        begin
            end_marker_next = (cfg_data < cct_pkg::MARKER_MIN) ? cct_pkg::MARKER_MIN
                                                               : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= cct_pkg::MARKER_RESET;
        end
        else
        begin
            end_marker_reg <= end_marker_next;
        end
    end

    cct_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .mode            (mode),
        .cluster         (cluster),
        .link_value      (link_value),
        .step_limit      (step_limit),
        .end_marker      (end_marker_reg),
        .busy            (busy),
        .done            (done),
        .result_value    (result_value),
        .entries_touched (entries_touched),
        .status          (status),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    cct_link_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command transfer produced neither work nor a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == cct_pkg::ST_FULL)) |-> (result_value == 16'd0))
        else $error("table full result carries a cluster");

    assert property (@(posedge clk) disable iff (!rst_n)
        end_marker_reg >= cct_pkg::MARKER_MIN)
        else $error("end marker below minimum");

endmodule

@@ tb/cluster_chain_table_checker.sv @@
// ----------------------------------------------------------------------------
// cluster_chain_table_checker
// Watches the command, result and end-marker ports of the cluster chain table
// engine. Keeps a shadow link table and end marker, predicts the result of
// every accepted command and compares each done strobe against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module cluster_chain_table_checker #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         mode,
    input  logic [15:0]        cluster,
    input  logic [15:0]        link_value,
    input  logic [12:0]        step_limit,
    input  logic               done,
    input  logic [15:0]        result_value,
    input  logic [12:0]        entries_touched,
    input  logic [1:0]         status,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    output int unsigned        mismatch_count,
    output int unsigned        results_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic [12:0] touched;
        logic [1:0]  code;
    } fat_result_t;

    logic [15:0] fat_shadow [TABLE_ENTRIES];
    logic [15:0] chain_end;
    fat_result_t expected_results [$];
    fat_result_t oldest;
    int unsigned fail_tally = 0;

    function automatic fat_result_t run_fat_op(input logic [2:0] op, input logic [15:0] idx,
                                               input logic [15:0] wval, input logic [12:0] lim);
        fat_result_t r;
        int unsigned cur;
        int unsigned nxt;
        int unsigned got;
        int unsigned steps;
        int unsigned skip;
        r = '0;
        steps = 0;
        got = 0;
        case (op)
            cct_pkg::MODE_READ:
            begin
                if (idx < TABLE_ENTRIES)
                    r.value = fat_shadow[idx];
                else
                    r.code = cct_pkg::ST_RANGE;
            end
            cct_pkg::MODE_WRITE:
            begin
                if (idx < TABLE_ENTRIES)
                    fat_shadow[idx] = wval;
                else
                    r.code = cct_pkg::ST_RANGE;
            end
            cct_pkg::MODE_ALLOC, cct_pkg::MODE_LINK:
            begin
                if (op == cct_pkg::MODE_LINK && idx >= TABLE_ENTRIES)
                begin
                    r.code = cct_pkg::ST_RANGE;
                end
                else
                begin
                    // skip the predecessor so an entry never links to itself
                    skip = (op == cct_pkg::MODE_LINK) ? idx : 0;
                    for (int unsigned i = cct_pkg::FIRST_DATA; i < TABLE_ENTRIES; i++)
                        if (got == 0 && i != skip && fat_shadow[i] == 16'd0)
                            got = i;
                    if (got == 0)
                    begin
                        r.code = cct_pkg::ST_FULL;
                    end
                    else
                    begin
                        fat_shadow[got] = chain_end;
                        if (op == cct_pkg::MODE_LINK)
                            fat_shadow[idx] = got[15:0];
                        r.value = got[15:0];
                    end
                end
            end
            cct_pkg::MODE_FREE:
            begin
                cur = idx;
                while (cur < chain_end)
                begin
                    if (cur >= TABLE_ENTRIES)
                    begin
                        r.code = cct_pkg::ST_RANGE;
                        break;
                    end
                    if (steps >= TABLE_ENTRIES)
                    begin
                        r.code = cct_pkg::ST_RUNAWAY;
                        break;
                    end
                    nxt = fat_shadow[cur];
                    fat_shadow[cur] = 16'd0;
                    steps++;
                    cur = nxt;
                end
                r.touched = steps[12:0];
            end
            cct_pkg::MODE_WALK:
            begin
                cur = idx;
                while (cur < chain_end && steps < lim)
                begin
                    if (cur >= TABLE_ENTRIES)
                    begin
                        r.code = cct_pkg::ST_RANGE;
                        break;
                    end
                    if (steps >= TABLE_ENTRIES)
                    begin
                        r.code = cct_pkg::ST_RUNAWAY;
                        break;
                    end
                    cur = fat_shadow[cur];
                    steps++;
                end
                r.value = cur[15:0];
                r.touched = steps[12:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (fat_shadow[i])
                fat_shadow[i] = 16'd0;
            chain_end = cct_pkg::MARKER_RESET;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no command waiting: result_value %0d",
                           result_value);
                    fail_tally++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (oldest.value !== result_value)
                    begin
                        $error("result_value: expected %0d, actual %0d", oldest.value,
                               result_value);
                        fail_tally++;
                    end
                    if (oldest.touched !== entries_touched)
                    begin
                        $error("entries_touched: expected %0d, actual %0d", oldest.touched,
                               entries_touched);
                        fail_tally++;
                    end
                    if (oldest.code !== status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.code, status);
                        fail_tally++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(run_fat_op(mode, cluster, link_value, step_limit));
            if (cfg_we)
                chain_end = (cfg_data < cct_pkg::MARKER_MIN) ? cct_pkg::MARKER_MIN : cfg_data;
        end
        mismatch_count  <= fail_tally;
        results_pending <= expected_results.size();
    end

endmodule

@@ tb/tb_cluster_chain_table_engine.sv @@
// ----------------------------------------------------------------------------
// tb_cluster_chain_table_engine
// Drives the cluster chain table engine with a directed command set, random
// chain-building traffic under several end markers and sender idle rates, and
// a runaway pass built from a short cyclic chain. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cluster_chain_table_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 4096;
    localparam int unsigned ITEMS_PER_PHASE = 150;
    localparam int unsigned N_PHASES = 4;
    localparam int unsigned CYCLE_END = 10;
    localparam int unsigned CYCLE_LIMIT =
        4 * ((ITEMS_PER_PHASE * N_PHASES + 64) * (TABLE_ENTRIES + 16) + TABLE_ENTRIES * 16);

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = '0;
    logic [15:0] cluster = '0;
    logic [15:0] link_value = '0;
    logic [12:0] step_limit = '0;
    logic        done;
    logic [15:0] result_value;
    logic [12:0] entries_touched;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    int unsigned mismatch_count;
    int unsigned results_pending;
    int unsigned idle_pct = 0;
    int unsigned cycle_count = 0;

    logic [2:0]  issued_modes [$];
    logic [15:0] alloc_pool [$];
    logic [2:0]  finished_mode;

    cluster_chain_table_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

    cluster_chain_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // track allocated clusters so random traffic builds real chains
    always @(posedge clk)
    begin
        if (rst_n && done && issued_modes.size() != 0)
        begin
            finished_mode = issued_modes.pop_front();
            if ((finished_mode == cct_pkg::MODE_ALLOC || finished_mode == cct_pkg::MODE_LINK)
                && status == cct_pkg::ST_OK)
            begin
                alloc_pool.push_back(result_value);
                if (alloc_pool.size() > 48)
                    void'(alloc_pool.pop_front());
            end
        end
    end

    function automatic logic [15:0] pick_cluster();
        if (alloc_pool.size() == 0)
            return 16'($urandom_range(2, 40));
        return alloc_pool[$urandom_range(alloc_pool.size() - 1)];
    endfunction

    task automatic send_command(input logic [2:0] m, input logic [15:0] c,
                                input logic [15:0] v, input logic [12:0] lim);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 12);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        cluster    <= c;
        link_value <= v;
        step_limit <= lim;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued_modes.push_back(m);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_end_marker(input logic [15:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] phase_marker [N_PHASES];
        int unsigned phase_idle [N_PHASES];
        int unsigned sel;
        logic [15:0] c;
        logic [15:0] v;
        logic [12:0] lim;

        phase_marker = '{16'h0000, 16'd65531, 16'hFFFF, 16'($urandom_range(0, 65535))};
        phase_idle   = '{0, 83, 17, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: end marker at its reset value, empty table
        send_command(cct_pkg::MODE_READ, 16'd0, 16'hFFFF, 13'h1FFF);
        send_command(cct_pkg::MODE_ALLOC, 16'hFFFF, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_ALLOC, 16'd0, 16'hFFFF, 13'h1FFF);
        send_command(cct_pkg::MODE_LINK, 16'd3, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_LINK, 16'd5, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd3, 16'd0, 13'h1FFF);
        send_command(cct_pkg::MODE_WALK, 16'd3, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd5, 16'd0, 13'd1);
        send_command(cct_pkg::MODE_WALK, 16'hFFFF, 16'd0, 13'd5);
        send_command(cct_pkg::MODE_FREE, 16'hFFFF, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WRITE, 16'd7, 16'd5000, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd7, 16'd0, 13'd10);
        send_command(cct_pkg::MODE_FREE, 16'd7, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_READ, 16'd4096, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_READ, 16'hFFFF, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WRITE, 16'd4096, 16'hFFFF, 13'd0);
        send_command(cct_pkg::MODE_LINK, 16'hFFFF, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_FREE, 16'd4096, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd9000, 16'd0, 13'd3);
        send_command(3'd6, 16'($urandom), 16'($urandom), 13'($urandom));
        send_command(3'd7, 16'($urandom), 16'($urandom), 13'($urandom));
        send_command(cct_pkg::MODE_WRITE, 16'd1, 16'hFFFF, 13'd0);
        send_command(cct_pkg::MODE_READ, 16'd1, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_FREE, 16'd3, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_READ, 16'd4, 16'd0, 13'd0);

        for (int unsigned p = 0; p < N_PHASES; p++)
        begin
            set_end_marker(phase_marker[p]);
            idle_pct = phase_idle[p];
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                sel = $urandom_range(99);
                lim = 13'($urandom_range(0, 24));
                if ($urandom_range(15) == 0)
                    lim = 13'($urandom);
                if (sel < 25)
                begin
                    // extend the newest chain most of the time
                    c = (alloc_pool.size() != 0 && $urandom_range(3) != 0) ?
                        alloc_pool[$] : pick_cluster();
                    send_command(cct_pkg::MODE_LINK, c, 16'($urandom), 13'($urandom));
                end
                else if (sel < 45)
                begin
                    send_command(cct_pkg::MODE_ALLOC, 16'($urandom), 16'($urandom),
                                 13'($urandom));
                end
                else if (sel < 65)
                begin
                    send_command(cct_pkg::MODE_WALK, pick_cluster(), 16'($urandom), lim);
                end
                else if (sel < 75)
                begin
                    c = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 4200)) : pick_cluster();
                    send_command(cct_pkg::MODE_READ, c, 16'($urandom), lim);
                end
                else if (sel < 89)
                begin
                    case ($urandom_range(3))
                        0: v = pick_cluster();
                        1: v = cct_pkg::MARKER_MIN + 16'($urandom_range(7));
                        2: v = 16'd0;
                        default: v = 16'($urandom);
                    endcase
                    c = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 63)) : pick_cluster();
                    send_command(cct_pkg::MODE_WRITE, c, v, lim);
                end
                else if (sel < 95)
                begin
                    send_command(cct_pkg::MODE_FREE, pick_cluster(), 16'($urandom), lim);
                end
                else
                begin
                    send_command(3'($urandom_range(7)), 16'($urandom), 16'($urandom), lim);
                end
            end
        end

        // build a short cyclic chain, then hit the walk-limit and runaway cases
        set_end_marker(cct_pkg::MARKER_MIN);
        idle_pct = 0;
        send_command(cct_pkg::MODE_WRITE, 16'd0, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WRITE, 16'd1, 16'd0, 13'd0);
        for (int unsigned i = cct_pkg::FIRST_DATA; i < CYCLE_END; i++)
            send_command(cct_pkg::MODE_WRITE, 16'(i),
                         (i == CYCLE_END - 1) ? 16'(cct_pkg::FIRST_DATA) : 16'(i + 1),
                         13'd0);
        send_command(cct_pkg::MODE_ALLOC, 16'd0, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_LINK, 16'd100, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_LINK, 16'd4096, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd2, 16'd0, 13'd4096);
        send_command(cct_pkg::MODE_WALK, 16'd2, 16'd0, 13'h1FFF);
        send_command(cct_pkg::MODE_FREE, 16'd2, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_ALLOC, 16'd0, 16'd0, 13'd0);
        send_command(cct_pkg::MODE_WALK, 16'd65530, 16'd0, 13'd4);

        drain_results();
        repeat (TABLE_ENTRIES + 16) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
